// File: rtl/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
// Used by ffba_cell and first_fit_block_allocator; depends on nothing else.
`timescale 1ns / 1ps

package ffba_pkg;

    // Sizing of the block table and of the block header.
    localparam int TABLE_ENTRIES = 16;
    localparam int HEADER_BYTES  = 16;

    // Field widths, fixed by the item formats.
    localparam int ADDR_W   = 24;
    localparam int SIZE_W   = 20;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 24;

    // Entry count width: holds 0 .. TABLE_ENTRIES.
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // Width of the append arithmetic: address plus size plus header, with carry.
    localparam int SUM_W = ADDR_W + 2;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_HEAP_LIMIT = 1'b0;

    // Operation codes.
    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 3'd0,
        ST_ZERO    = 3'd1,
        ST_FULL    = 3'd2,
        ST_SPACE   = 3'd3,
        ST_UNKNOWN = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_APPEND = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    // One request item.
    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_address;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   payload_address;
    } t_out_item;

    // Search token that walks down the row of cells.
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [ADDR_W-1:0] paddr;
    } t_probe;

    // Broadcast write of a newly appended block.
    typedef struct packed {
        logic              en;
        logic [CNT_W-1:0]  index;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] bytes;
    } t_append;

endpackage

// File: rtl/ffba_cell.sv
// One table entry of the allocator together with its stage of the search token.
// Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_cell
    import ffba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_index,
    input  logic [CNT_W-1:0] i_used,
    input  t_probe           i_probe,
    input  t_append          i_wr,
    output t_probe           o_probe
);

    logic              r_valid;
    t_probe            r_data;
    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_bytes;
    logic              r_free;

    t_probe            n_data;
    logic              n_free;
    logic [ADDR_W-1:0] w_hdr_addr;
    logic              w_live;
    logic              w_hit_alloc;
    logic              w_hit_rel;
    logic              w_wr_here;

    // The entry takes part only while it lies below the fill count.
    assign w_hdr_addr  = r_base + ADDR_W'(HEADER_BYTES);
    assign w_live      = i_probe.valid && !i_probe.found && (i_index < i_used);
    assign w_hit_alloc = w_live && (i_probe.op == OP_ALLOC) && r_free &&
                         (r_bytes >= i_probe.size);
    assign w_hit_rel   = w_live && (i_probe.op == OP_RELEASE) &&
                         (w_hdr_addr == i_probe.addr);
    assign w_wr_here   = i_wr.en && (i_wr.index == i_index);

    // A hit claims the token and hands this entry's payload address onward.
    always_comb begin
        n_data = i_probe;
        if (w_hit_alloc || w_hit_rel) begin
            n_data.found = 1'b1;
            n_data.paddr = w_hdr_addr;
        end
    end

    // Free mark: an append or an allocate hit clears it, a release hit sets it.
    always_comb begin
        n_free = r_free;
        priority if (w_wr_here) begin
            n_free = 1'b0;
        end else if (w_hit_alloc) begin
            n_free = 1'b0;
        end else if (w_hit_rel) begin
            n_free = 1'b1;
        end else begin
            n_free = r_free;
        end
    end

    // Token stage: valid is control, the rest is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_probe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_free <= n_free;
        if (w_wr_here) begin
            r_base  <= i_wr.base;
            r_bytes <= i_wr.bytes;
        end
    end

    always_comb begin
        o_probe       = r_data;
        o_probe.valid = r_valid;
    end

endmodule

// File: rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: controller, registers and the row of cells.
// Depends on ffba_pkg and ffba_cell.
`timescale 1ns / 1ps

// Usage:
// Requests arrive on the input channel (i_in_valid / o_in_ready, payload i_in) and
// each one yields exactly one result on the output channel (o_out_valid /
// i_out_ready, payload o_out). An allocate takes the lowest free entry that is
// large enough, or else appends a block at the bump pointer; a release frees the
// entry whose payload address matches.
// The search token walks one cell per cycle through TABLE_ENTRIES cells; the result
// then goes through S_APPEND when a block is appended, waits in S_RESULT and is
// loaded into the output register.
// One request is in work at a time; o_in_ready rises again in the cycle the
// result appears in the output register, so a new request is taken only once
// the last result is loaded. When the receiver stalls, the finished result waits
// in the controller until the output register is free, and no new request is taken.
// A synchronous reset empties the table, clears the bump pointer, sets heap_limit to
// all ones and drops o_out_valid; no clearing pass is needed. heap_limit is to be
// written through the APB-style port only while the block is idle; nothing enforces it.

module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_state             r_state;
    t_state             n_state;
    t_in_item           r_req;
    t_out_item          r_res;
    t_out_item          n_res;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   n_used;
    logic [ADDR_W-1:0]  r_bump;
    logic [ADDR_W-1:0]  n_bump;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_out_valid;
    t_out_item          r_out;

    t_probe             w_probe [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_pv;
    t_probe             w_tail;
    t_append            w_wr;
    logic               w_accept;
    logic               w_load;
    logic               w_cfg_wr;
    logic [SUM_W-1:0]   w_last;
    logic               w_no_space;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HEAP_LIMIT);
    assign prdata   = (paddr[2] == REG_HEAP_LIMIT) ?
                      {{(PDATA_W-LIMIT_W){1'b0}}, r_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '1;
        end else if (w_cfg_wr) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // Handshakes.
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Token injection: zero-size allocates and releases of address zero are
    // settled at entry, so they pass the row untouched.
    always_comb begin
        w_probe[0].valid = w_accept;
        w_probe[0].op    = t_op'(i_in.op);
        w_probe[0].size  = i_in.request_size;
        w_probe[0].addr  = i_in.release_address;
        w_probe[0].found = ((i_in.op == OP_ALLOC) && (i_in.request_size == '0)) ||
                           ((i_in.op == OP_RELEASE) && (i_in.release_address == '0));
        w_probe[0].paddr = '0;
    end

    // Row of table cells.
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        ffba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (CNT_W'(k)),
            .i_used  (r_used),
            .i_probe (w_probe[k]),
            .i_wr    (w_wr),
            .o_probe (w_probe[k+1])
        );
        assign w_pv[k] = w_probe[k+1].valid;
    end

    assign w_tail = w_probe[TABLE_ENTRIES];

    // Append arithmetic: last byte of the new block and the space check.
    assign w_last = SUM_W'(r_bump) + SUM_W'(r_req.request_size) +
                    SUM_W'(HEADER_BYTES) - SUM_W'(1);
    assign w_no_space = (w_last > SUM_W'(r_limit)) ||
                        (w_last >= SUM_W'({ADDR_W{1'b1}}));

    always_comb begin
        w_wr.en    = (r_state == S_APPEND) && !w_no_space;
        w_wr.index = r_used;
        w_wr.base  = r_bump;
        w_wr.bytes = r_req.request_size;
    end

    // Controller.
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_used  = r_used;
        n_bump  = r_bump;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tail.valid) begin
                    n_state               = S_RESULT;
                    n_res.status          = ST_DONE;
                    n_res.payload_address = '0;
                    if ((r_req.op == OP_ALLOC) && (r_req.request_size == '0)) begin
                        n_res.status = ST_ZERO;
                    end else if (w_tail.found) begin
                        if (r_req.op == OP_ALLOC) begin
                            n_res.payload_address = w_tail.paddr;
                        end
                    end else if (r_req.op == OP_RELEASE) begin
                        n_res.status = ST_UNKNOWN;
                    end else if (r_used == CNT_W'(TABLE_ENTRIES)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_APPEND: begin
                n_state = S_RESULT;
                if (w_no_space) begin
                    n_res.status          = ST_SPACE;
                    n_res.payload_address = '0;
                end else begin
                    n_res.status          = ST_DONE;
                    n_res.payload_address = r_bump + ADDR_W'(HEADER_BYTES);
                    n_used                = r_used + CNT_W'(1);
                    n_bump                = w_last[ADDR_W-1:0] + ADDR_W'(1);
                end
            end
            S_RESULT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_bump      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_bump  <= n_bump;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_accept) begin
            r_req <= i_in;
        end
        if (w_load) begin
            r_out <= r_res;
        end
    end

    // Only one search token is ever in the row.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_pv) <= 1)
        else $error("more than one search token in the cell row");

    // No token may remain in the row once the controller is idle.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_pv == '0))
        else $error("search token present while idle");

    // The fill count never passes the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // An input transfer starts a scan in the next cycle.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN))
        else $error("accepted request did not start a scan");

endmodule

// File: tb/testbench.sv
// Self-checking testbench of the first-fit block allocator.
// Holds its own model of the block table, bump pointer and heap limit;
// depends on ffba_pkg and first_fit_block_allocator.
`timescale 1ns / 1ps

module testbench;
    import ffba_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 300;

    // Kinds of rows in the directed stimulus.
    typedef enum {
        ROW_REQ,
        ROW_TOP,
        ROW_LIMIT
    } t_row_kind;

    // One directed row. ROW_LIMIT carries the new limit in release_address;
    // ROW_TOP carries in request_size how far below the top of memory the block ends.
    typedef struct {
        t_row_kind kind;
        int        rep;
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Model state of the allocator.
    logic [ADDR_W-1:0]  blk_base [TABLE_ENTRIES];
    logic [SIZE_W-1:0]  blk_bytes[TABLE_ENTRIES];
    logic               blk_free [TABLE_ENTRIES];
    int unsigned        blk_count;
    logic [ADDR_W-1:0]  bump_model;
    logic [LIMIT_W-1:0] limit_model;

    t_out_item pending_results[$];
    t_stim_row directed_rows[$];
    int        mismatches = 0;
    bit        calm = 1'b0;
    bit        hold_off_req = 1'b0;

    first_fit_block_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Predicts the result of one request and updates the model table.
    function automatic t_out_item alloc_predict(input t_in_item req);
        t_out_item   res;
        logic [31:0] last;
        bit          hit;
        res.status          = ST_DONE;
        res.payload_address = '0;
        hit                 = 1'b0;
        if (req.op == OP_ALLOC) begin
            if (req.request_size == '0) begin
                res.status = ST_ZERO;
            end else begin
                // First fit among the valid entries, no split.
                for (int i = 0; i < blk_count; i++) begin
                    if (!hit && blk_free[i] && blk_bytes[i] >= req.request_size) begin
                        hit                 = 1'b1;
                        blk_free[i]         = 1'b0;
                        res.payload_address = blk_base[i] + ADDR_W'(HEADER_BYTES);
                    end
                end
                if (!hit) begin
                    last = 32'(bump_model) + 32'(req.request_size) + HEADER_BYTES - 1;
                    if (blk_count >= TABLE_ENTRIES) begin
                        res.status = ST_FULL;
                    end else if (last > 32'(limit_model) || last >= 32'hFF_FFFF) begin
                        res.status = ST_SPACE;
                    end else begin
                        blk_base[blk_count]  = bump_model;
                        blk_bytes[blk_count] = req.request_size;
                        blk_free[blk_count]  = 1'b0;
                        blk_count++;
                        res.payload_address = bump_model + ADDR_W'(HEADER_BYTES);
                        bump_model          = last[ADDR_W-1:0] + 1'b1;
                    end
                end
            end
        end else if (req.release_address != '0) begin
            for (int i = 0; i < blk_count; i++) begin
                if (!hit && blk_base[i] + ADDR_W'(HEADER_BYTES) == req.release_address) begin
                    hit         = 1'b1;
                    blk_free[i] = 1'b1;
                end
            end
            if (!hit) res.status = ST_UNKNOWN;
        end
        return res;
    endfunction

    // Random request: mostly releases of live blocks and allocations of any size.
    function automatic t_in_item random_request();
        t_in_item req;
        int       pick;
        pick                = $urandom_range(99);
        req.request_size    = SIZE_W'($urandom);
        req.release_address = ADDR_W'($urandom);
        if (pick < 45 && blk_count > 0) begin
            req.op              = OP_RELEASE;
            req.release_address = blk_base[$urandom_range(blk_count - 1)]
                                  + ADDR_W'(HEADER_BYTES);
        end else if (pick < 52) begin
            req.op = OP_RELEASE;
        end else if (pick < 55) begin
            req.op              = OP_RELEASE;
            req.release_address = '0;
        end else begin
            req.op = OP_ALLOC;
            if (pick < 59) req.request_size = '0;
            else if (pick < 72) req.request_size = SIZE_W'($urandom_range(20'hFFFFF, 20'hFFE00));
            else if (pick < 80) req.request_size = SIZE_W'($urandom_range(64, 1));
        end
        return req;
    endfunction

    function automatic t_stim_row mk_row(input t_row_kind kind, input int rep, input t_op op,
                                         input logic [SIZE_W-1:0] size,
                                         input logic [ADDR_W-1:0] addr, input bit typed,
                                         input t_status st, input logic [ADDR_W-1:0] pa);
        t_stim_row r;
        r.kind                   = kind;
        r.rep                    = rep;
        r.req.op                 = op;
        r.req.request_size       = size;
        r.req.release_address    = addr;
        r.typed                  = typed;
        r.want.status            = st;
        r.want.payload_address   = pa;
        return r;
    endfunction

    // Offers one request, holding it until its transfer, and records the expectation.
    task automatic offer(input t_in_item req, input bit typed, input t_out_item want);
        t_out_item res;
        while (!calm && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = alloc_predict(req);
        pending_results.push_back(typed ? want : res);
    endtask

    // Waits until every expected result has arrived and the block has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes heap_limit over the configuration port and reads it back.
    task automatic program_heap_limit(input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_HEAP_LIMIT, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_model = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        paddr   <= {REG_HEAP_LIMIT, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== PDATA_W'(value)) begin
            $error("heap_limit read back: expected 0x%08h, actual 0x%08h",
                   PDATA_W'(value), prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    initial begin : result_sink
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 34);
            end
        end
    end

    // Each result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected: status %0d, payload_address 0x%06h",
                       o_out.status, o_out.payload_address);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_out.status);
                    mismatches++;
                end
                if (o_out.payload_address !== want.payload_address) begin
                    $error("payload_address: expected 0x%06h, actual 0x%06h",
                           want.payload_address, o_out.payload_address);
                    mismatches++;
                end
            end
        end
    end

    // Main stimulus: directed rows, then random phases under several limits.
    initial begin : stimulus
        t_in_item    req;
        logic [31:0] fit;
        logic [LIMIT_W-1:0] phase_limit;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        blk_count  = 0;
        bump_model = '0;
        limit_model = '1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            blk_base[i]  = '0;
            blk_bytes[i] = '0;
            blk_free[i]  = 1'b0;
        end

        // Zero size, release of zero, and the first append after reset.
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_ALLOC, 20'h0, 24'h0, 1, ST_ZERO, 24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_RELEASE, 20'hFFFFF, 24'h0, 1, ST_DONE,
                                       24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_ALLOC, 20'hFFFFF, 24'hFFFFFF, 1, ST_DONE,
                                       24'h10));
        // Limit below the bump pointer: no append fits.
        directed_rows.push_back(mk_row(ROW_LIMIT, 1, OP_ALLOC, 20'h0, 24'h0, 0, ST_DONE, 24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_ALLOC, 20'h1, 24'h0, 1, ST_SPACE, 24'h0));
        // Limit on the last byte of a block one byte short of the largest.
        directed_rows.push_back(mk_row(ROW_LIMIT, 1, OP_ALLOC, 20'h0, 24'h20001C, 0, ST_DONE,
                                       24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_ALLOC, 20'hFFFFF, 24'h0, 1, ST_SPACE,
                                       24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_ALLOC, 20'hFFFFE, 24'h0, 1, ST_DONE,
                                       24'h10001F));
        // Full limit, then fill memory up to just below its top.
        directed_rows.push_back(mk_row(ROW_LIMIT, 1, OP_ALLOC, 20'h0, 24'hFFFFFF, 0, ST_DONE,
                                       24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 13, OP_ALLOC, 20'hFFFFF, 24'h0, 0, ST_DONE,
                                       24'h0));
        // A block ending on the very last address overflows the bump pointer.
        directed_rows.push_back(mk_row(ROW_TOP, 1, OP_ALLOC, 20'h0, 24'h0, 1, ST_SPACE, 24'h0));
        directed_rows.push_back(mk_row(ROW_TOP, 1, OP_ALLOC, 20'h1, 24'h0, 0, ST_DONE, 24'h0));
        // Table full, release, release of a free block, reuse, unknown address.
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_ALLOC, 20'h1, 24'h0, 1, ST_FULL, 24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_RELEASE, 20'h0, 24'h10, 1, ST_DONE,
                                       24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_RELEASE, 20'h0, 24'h10, 1, ST_DONE,
                                       24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_ALLOC, 20'hFFFFF, 24'h0, 1, ST_DONE,
                                       24'h10));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_RELEASE, 20'h0, 24'h11, 1, ST_UNKNOWN,
                                       24'h0));
        directed_rows.push_back(mk_row(ROW_REQ, 1, OP_RELEASE, 20'h0, 24'h10001F, 0, ST_DONE,
                                       24'h0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_LIMIT) begin
                drain();
                program_heap_limit(directed_rows[n].req.release_address);
            end else begin
                repeat (directed_rows[n].rep) begin
                    req = directed_rows[n].req;
                    if (directed_rows[n].kind == ROW_TOP) begin
                        fit = 32'h0100_0000 - 32'(bump_model) - HEADER_BYTES
                              - 32'(directed_rows[n].req.request_size);
                        req.request_size = fit[SIZE_W-1:0];
                    end
                    offer(req, directed_rows[n].typed, directed_rows[n].want);
                end
            end
        end

        // Random phases; the second runs without idling, the third holds off the receiver.
        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: phase_limit = LIMIT_W'($urandom);
                1: phase_limit = '0;
                2: phase_limit = '1;
                default: phase_limit = LIMIT_W'($urandom);
            endcase
            program_heap_limit(phase_limit);
            calm = (p == 1);
            if (p == 2) hold_off_req = 1'b1;
            @(posedge i_clk);
            repeat (PHASE_ITEMS) offer(random_request(), 1'b0, '0);
        end
        calm = 1'b0;

        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: first_fit_block_allocator.f
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/first_fit_block_allocator.sv
tb/testbench.sv
